>>> src/nppl_pkg.sv
package nppl_pkg;

    // Field widths
    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 8;
    localparam int OUT_BITS   = 32;
    localparam int DIR_BITS   = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    // Internal widths
    localparam int DW        = COORD_BITS + 1;          // coordinate difference
    localparam int L2W       = 2 * COORD_BITS + 2;      // squared segment length
    localparam int DOTW      = 2 * COORD_BITS + 3;      // signed dot product
    localparam int EW        = COORD_BITS + FRAC_BITS + 3; // scaled point / offset
    localparam int DIR_SHIFT = 30;
    localparam int LQW       = COORD_BITS + 17;         // scaled segment length

    // Shared unit width: largest of foot numerator, length radicand, foot radicand
    localparam int WA   = 3 * COORD_BITS + FRAC_BITS + 4;
    localparam int WB   = L2W + DIR_SHIFT;
    localparam int WC   = 2 * EW + 1;
    localparam int WAB  = (WA > WB) ? WA : WB;
    localparam int WMAX = (WAB > WC) ? WAB : WC;
    localparam int WIDE = ((WMAX + 1) / 2) * 2;
    localparam int CNTW = $clog2(WIDE + 1);
    localparam int SQTOP = WIDE - 2;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUERY_X  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUERY_Y  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DIST = 2'd2;

    localparam logic signed [DIR_BITS-1:0] Q15_ONE = 16'sd32767;
    localparam logic signed [DIR_BITS-1:0] Q15_MIN = -16'sd32768;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } arith_ctrl_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_L2X, ST_L2Y, ST_LQ, ST_UX, ST_UY,
        ST_E1X, ST_E1Y, ST_E1S,
        ST_E2X, ST_E2Y, ST_E2S,
        ST_DOT1, ST_DOT2,
        ST_FXM, ST_FXD, ST_FYM, ST_FYD,
        ST_FEX, ST_FEY, ST_FES,
        ST_EMIT
    } state_t;

endpackage

>>> src/nppl_arith.sv
// Shared iterative unit: shift-add multiply (acc = c + a*b), restoring
// divide (a / b), digit-by-digit square root (floor sqrt a). One bit per cycle.
module nppl_arith
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  nppl_pkg::arith_ctrl_t         ctrl,
    input  logic [nppl_pkg::WIDE-1:0]     a_in,
    input  logic [nppl_pkg::WIDE-1:0]     b_in,
    input  logic [nppl_pkg::WIDE-1:0]     c_in,
    output logic                          done,
    output logic [nppl_pkg::WIDE-1:0]     res
);

    localparam int W = nppl_pkg::WIDE;

    logic [W-1:0]                  a_reg, a_next;
    logic [W-1:0]                  b_reg, b_next;
    logic [W:0]                    acc_reg, acc_next;
    logic [nppl_pkg::CNTW-1:0]     cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    nppl_pkg::op_t                 op_reg, op_next;

    logic [W:0]   sub_l, sub_r;
    logic [W+1:0] diff;
    logic         ge;
    logic         fin;

    // Shared compare/subtract
    always_comb
    begin
        if (op_reg == nppl_pkg::OP_DIV)
        begin
            sub_l = {acc_reg[W-1:0], a_reg[W-1]};
            sub_r = {1'b0, b_reg};
        end
        else
        begin
            sub_l = {1'b0, a_reg};
            sub_r = {1'b0, acc_reg[W-1:0] | b_reg};
        end
        diff = {1'b0, sub_l} - {1'b0, sub_r};
        ge   = ~diff[W+1];
    end

    // End of an operation
    always_comb
    begin
        case (op_reg)
            nppl_pkg::OP_MUL:  fin = (b_reg == '0);
            nppl_pkg::OP_DIV:  fin = (cnt_reg == '0);
            nppl_pkg::OP_SQRT: fin = (b_reg == '0);
            default:           fin = 1'b1;
        endcase
    end

    assign done = busy_reg & fin;
    assign res  = (op_reg == nppl_pkg::OP_DIV) ? a_reg : acc_reg[W-1:0];

    // Step logic
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        op_next   = op_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            op_next   = ctrl.op;
            a_next    = a_in;
            cnt_next  = nppl_pkg::CNTW'(W);
            case (ctrl.op)
                nppl_pkg::OP_MUL:
                begin
                    b_next   = b_in;
                    acc_next = {1'b0, c_in};
                end
                nppl_pkg::OP_DIV:
                begin
                    b_next   = b_in;
                    acc_next = '0;
                end
                nppl_pkg::OP_SQRT:
                begin
                    b_next   = W'(1) << nppl_pkg::SQTOP;
                    acc_next = '0;
                end
                default:
                begin
                    b_next   = '0;
                    acc_next = '0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            if (fin)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                case (op_reg)
                    nppl_pkg::OP_MUL:
                    begin
                        if (b_reg[0])
                        begin
                            acc_next = acc_reg + {1'b0, a_reg};
                        end
                        a_next = a_reg << 1;
                        b_next = b_reg >> 1;
                    end
                    nppl_pkg::OP_DIV:
                    begin
                        acc_next = ge ? diff[W:0] : sub_l;
                        a_next   = {a_reg[W-2:0], ge};
                        cnt_next = cnt_reg - nppl_pkg::CNTW'(1);
                    end
                    nppl_pkg::OP_SQRT:
                    begin
                        if (ge)
                        begin
                            a_next   = diff[W-1:0];
                            acc_next = (acc_reg >> 1) + {1'b0, b_reg};
                        end
                        else
                        begin
                            acc_next = acc_reg >> 1;
                        end
                        b_next = b_reg >> 2;
                    end
                    default:
                    begin
                        acc_next = acc_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            op_reg   <= nppl_pkg::OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

endmodule

>>> src/nearest_point_on_polylines.sv
// Timing: a vertex that tests no segment leaves the sequencer in IDLE, or moves it
// to EMIT when it is the last vertex; a vertex that closes a tested segment runs
// the shared multiply/divide/root unit for each step (multiplies stop early on
// short operands). Vertices are worked one at a time; the shared unit is the limit.
// A result waits in an output register while the next vertex is accepted.
// Reset: query point zero, radius all ones, no previous vertex, best state armed.
module nearest_point_on_polylines
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_stall,
    input  logic signed [nppl_pkg::COORD_BITS-1:0]        vertex_x,
    input  logic signed [nppl_pkg::COORD_BITS-1:0]        vertex_y,
    input  logic                                          starts_polyline,
    input  logic                                          object_selected,
    input  logic                                          last_vertex,
    output logic                                          out_valid,
    input  logic                                          out_stall,
    output logic signed [nppl_pkg::OUT_BITS-1:0]          nearest_x,
    output logic signed [nppl_pkg::OUT_BITS-1:0]          nearest_y,
    output logic signed [nppl_pkg::DIR_BITS-1:0]          direction_x,
    output logic signed [nppl_pkg::DIR_BITS-1:0]          direction_y,
    output logic [nppl_pkg::OUT_BITS-1:0]                 distance,
    input  logic                                          cfg_valid,
    output logic                                          cfg_ready,
    input  logic [nppl_pkg::CFG_IDX_BITS-1:0]             cfg_index,
    input  logic [nppl_pkg::CFG_DATA_BITS-1:0]            cfg_data
);

    localparam int W  = nppl_pkg::WIDE;
    localparam int C  = nppl_pkg::COORD_BITS;
    localparam int F  = nppl_pkg::FRAC_BITS;
    localparam int DW = nppl_pkg::DW;
    localparam int EW = nppl_pkg::EW;
    localparam int OB = nppl_pkg::OUT_BITS;
    localparam int DB = nppl_pkg::DIR_BITS;

    nppl_pkg::state_t state_reg, state_next;
    logic             issued_reg, issued_next;

    // Configuration
    logic signed [C-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic [OB-1:0]       maxd_reg, maxd_next;

    // Vertices
    logic signed [C-1:0] prevx_reg, prevx_next, prevy_reg, prevy_next;
    logic                prev_valid_reg, prev_valid_next;
    logic signed [C-1:0] x1_reg, x1_next, y1_reg, y1_next;
    logic                last_reg, last_next;

    // Segment work
    logic [nppl_pkg::L2W-1:0]          l2_reg, l2_next;
    logic [nppl_pkg::LQW-1:0]          lq_reg, lq_next;
    logic signed [DB-1:0]              ux_reg, ux_next, uy_reg, uy_next;
    logic signed [nppl_pkg::DOTW-1:0]  dot_reg, dot_next;
    logic signed [EW-1:0]              fx_reg, fx_next, fy_reg, fy_next;

    // Best so far
    logic [OB-1:0]        bdist_reg, bdist_next;
    logic signed [OB-1:0] bpx_reg, bpx_next, bpy_reg, bpy_next;
    logic signed [DB-1:0] bdx_reg, bdx_next, bdy_reg, bdy_next;

    // Output word
    logic                 out_valid_reg, out_valid_next;
    logic signed [OB-1:0] opx_reg, opx_next, opy_reg, opy_next;
    logic signed [DB-1:0] odx_reg, odx_next, ody_reg, ody_next;
    logic [OB-1:0]        odist_reg, odist_next;

    // Shared unit
    nppl_pkg::arith_ctrl_t actrl;
    logic [W-1:0]          a_op, b_op, c_op, res;
    logic                  done;

    // Derived values
    logic signed [DW-1:0] dx, dy, ax, ay, bx, by;
    logic [DW-1:0]        adx, ady, aax, aay, abx, aby;
    logic signed [EW-1:0] sqx, sqy, sx1, sy1, sx2, sy2, ex, ey;
    logic signed [EW-1:0] sqx_next, sqy_next;
    logic [EW-1:0]        aex, aey;
    logic signed [EW-1:0] q_s;
    logic signed [nppl_pkg::DOTW-1:0] m_s, dot_sum;
    logic                 foot_ok;
    logic [OB-1:0]        cand_dist;
    logic signed [OB-1:0] cand_px, cand_py;
    logic                 in_acc, cfg_acc, cap, is_op, out_free, doseg;
    nppl_pkg::state_t     fin_state;

    function automatic logic signed [DB-1:0] dir_sat(input logic [W-1:0] q, input logic neg);
        logic signed [DB-1:0] r;
        logic signed [DB-1:0] low;
        low = signed'({1'b0, q[DB-2:0]});
        if (|q[W-1:DB-1])
        begin
            r = neg ? nppl_pkg::Q15_MIN : nppl_pkg::Q15_ONE;
        end
        else
        begin
            r = neg ? -low : low;
        end
        return r;
    endfunction

    nppl_arith u_arith
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (actrl),
        .a_in  (a_op),
        .b_in  (b_op),
        .c_in  (c_op),
        .done  (done),
        .res   (res)
    );

    // Handshakes
    assign in_stall  = (state_reg != nppl_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == nppl_pkg::ST_IDLE);
    assign in_acc    = in_valid & ~in_stall;
    assign cfg_acc   = cfg_valid & cfg_ready;
    assign out_free  = ~out_valid_reg | ~out_stall;
    assign cap       = issued_reg & done;
    assign is_op     = (state_reg != nppl_pkg::ST_IDLE) && (state_reg != nppl_pkg::ST_EMIT);
    assign doseg     = ~starts_polyline & prev_valid_reg & object_selected;
    assign fin_state = last_reg ? nppl_pkg::ST_EMIT : nppl_pkg::ST_IDLE;

    // Segment geometry (x1 = previous vertex, prev = this vertex)
    assign dx = DW'(prevx_reg) - DW'(x1_reg);
    assign dy = DW'(prevy_reg) - DW'(y1_reg);
    assign ax = DW'(qx_reg) - DW'(x1_reg);
    assign ay = DW'(qy_reg) - DW'(y1_reg);
    assign bx = DW'(qx_reg) - DW'(prevx_reg);
    assign by = DW'(qy_reg) - DW'(prevy_reg);
    assign adx = dx[DW-1] ? -dx : dx;
    assign ady = dy[DW-1] ? -dy : dy;
    assign aax = ax[DW-1] ? -ax : ax;
    assign aay = ay[DW-1] ? -ay : ay;
    assign abx = bx[DW-1] ? -bx : bx;
    assign aby = by[DW-1] ? -by : by;

    assign sqx = EW'(qx_reg) <<< F;
    assign sqy = EW'(qy_reg) <<< F;
    assign sx1 = EW'(x1_reg) <<< F;
    assign sy1 = EW'(y1_reg) <<< F;
    assign sx2 = EW'(prevx_reg) <<< F;
    assign sy2 = EW'(prevy_reg) <<< F;
    assign sqx_next = EW'(qx_next) <<< F;
    assign sqy_next = EW'(qy_next) <<< F;
    assign ex  = sqx - fx_reg;
    assign ey  = sqy - fy_reg;
    assign aex = ex[EW-1] ? -ex : ex;
    assign aey = ey[EW-1] ? -ey : ey;

    // Product, quotient and dot product terms from the unit result
    assign q_s     = signed'(res[EW-1:0]);
    assign m_s     = signed'(res[nppl_pkg::DOTW-1:0]);
    assign dot_sum = dot_reg + ((ay[DW-1] ^ dy[DW-1]) ? -m_s : m_s);
    assign foot_ok = ~dot_sum[nppl_pkg::DOTW-1] && (dot_sum <= signed'({1'b0, l2_reg}));

    // Candidate distance saturates to 32 bits
    assign cand_dist = (|res[W-1:OB]) ? '1 : res[OB-1:0];

    always_comb
    begin
        case (state_reg)
            nppl_pkg::ST_E1S:
            begin
                cand_px = OB'(sx1);
                cand_py = OB'(sy1);
            end
            nppl_pkg::ST_E2S:
            begin
                cand_px = OB'(sx2);
                cand_py = OB'(sy2);
            end
            default:
            begin
                cand_px = OB'(fx_reg);
                cand_py = OB'(fy_reg);
            end
        endcase
    end

    // Sequencer: next state
    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        if (is_op)
        begin
            if (!issued_reg)
            begin
                issued_next = 1'b1;
            end
            else if (done)
            begin
                issued_next = 1'b0;
            end
        end
        case (state_reg)
            nppl_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (doseg)
                    begin
                        state_next = nppl_pkg::ST_L2X;
                    end
                    else if (last_vertex)
                    begin
                        state_next = nppl_pkg::ST_EMIT;
                    end
                end
            end
            nppl_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = nppl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                if (cap)
                begin
                    case (state_reg)
                        nppl_pkg::ST_L2X:  state_next = nppl_pkg::ST_L2Y;
                        nppl_pkg::ST_L2Y:  state_next = (res == '0) ? nppl_pkg::ST_E1X
                                                                    : nppl_pkg::ST_LQ;
                        nppl_pkg::ST_LQ:   state_next = nppl_pkg::ST_UX;
                        nppl_pkg::ST_UX:   state_next = nppl_pkg::ST_UY;
                        nppl_pkg::ST_UY:   state_next = nppl_pkg::ST_E1X;
                        nppl_pkg::ST_E1X:  state_next = nppl_pkg::ST_E1Y;
                        nppl_pkg::ST_E1Y:  state_next = nppl_pkg::ST_E1S;
                        nppl_pkg::ST_E1S:  state_next = nppl_pkg::ST_E2X;
                        nppl_pkg::ST_E2X:  state_next = nppl_pkg::ST_E2Y;
                        nppl_pkg::ST_E2Y:  state_next = nppl_pkg::ST_E2S;
                        nppl_pkg::ST_E2S:  state_next = (l2_reg == '0) ? fin_state
                                                                       : nppl_pkg::ST_DOT1;
                        nppl_pkg::ST_DOT1: state_next = nppl_pkg::ST_DOT2;
                        nppl_pkg::ST_DOT2: state_next = foot_ok ? nppl_pkg::ST_FXM : fin_state;
                        nppl_pkg::ST_FXM:  state_next = nppl_pkg::ST_FXD;
                        nppl_pkg::ST_FXD:  state_next = nppl_pkg::ST_FYM;
                        nppl_pkg::ST_FYM:  state_next = nppl_pkg::ST_FYD;
                        nppl_pkg::ST_FYD:  state_next = nppl_pkg::ST_FEX;
                        nppl_pkg::ST_FEX:  state_next = nppl_pkg::ST_FEY;
                        nppl_pkg::ST_FEY:  state_next = nppl_pkg::ST_FES;
                        default:           state_next = fin_state;
                    endcase
                end
            end
        endcase
    end

    // Sequencer: unit command and operands
    always_comb
    begin
        actrl.start = is_op & ~issued_reg;
        actrl.op    = nppl_pkg::OP_MUL;
        a_op        = '0;
        b_op        = '0;
        c_op        = '0;
        case (state_reg)
            nppl_pkg::ST_L2X:
            begin
                a_op = W'(adx);
                b_op = W'(adx);
            end
            nppl_pkg::ST_L2Y:
            begin
                a_op = W'(ady);
                b_op = W'(ady);
                c_op = res;
            end
            nppl_pkg::ST_LQ:
            begin
                actrl.op = nppl_pkg::OP_SQRT;
                a_op     = W'(l2_reg) << nppl_pkg::DIR_SHIFT;
            end
            nppl_pkg::ST_UX:
            begin
                actrl.op = nppl_pkg::OP_DIV;
                a_op     = W'(adx) << nppl_pkg::DIR_SHIFT;
                b_op     = W'(lq_reg);
            end
            nppl_pkg::ST_UY:
            begin
                actrl.op = nppl_pkg::OP_DIV;
                a_op     = W'(ady) << nppl_pkg::DIR_SHIFT;
                b_op     = W'(lq_reg);
            end
            nppl_pkg::ST_E1X:
            begin
                a_op = W'(aax) << (2 * F);
                b_op = W'(aax);
            end
            nppl_pkg::ST_E1Y:
            begin
                a_op = W'(aay) << (2 * F);
                b_op = W'(aay);
                c_op = res;
            end
            nppl_pkg::ST_E2X:
            begin
                a_op = W'(abx) << (2 * F);
                b_op = W'(abx);
            end
            nppl_pkg::ST_E2Y:
            begin
                a_op = W'(aby) << (2 * F);
                b_op = W'(aby);
                c_op = res;
            end
            nppl_pkg::ST_E1S, nppl_pkg::ST_E2S, nppl_pkg::ST_FES:
            begin
                actrl.op = nppl_pkg::OP_SQRT;
                a_op     = res;
            end
            nppl_pkg::ST_DOT1:
            begin
                a_op = W'(aax);
                b_op = W'(adx);
            end
            nppl_pkg::ST_DOT2:
            begin
                a_op = W'(aay);
                b_op = W'(ady);
            end
            nppl_pkg::ST_FXM:
            begin
                a_op = W'(dot_reg[nppl_pkg::DOTW-2:0]) << F;
                b_op = W'(adx);
                c_op = W'(l2_reg >> 1);
            end
            nppl_pkg::ST_FYM:
            begin
                a_op = W'(dot_reg[nppl_pkg::DOTW-2:0]) << F;
                b_op = W'(ady);
                c_op = W'(l2_reg >> 1);
            end
            nppl_pkg::ST_FXD, nppl_pkg::ST_FYD:
            begin
                actrl.op = nppl_pkg::OP_DIV;
                a_op     = res;
                b_op     = W'(l2_reg);
            end
            nppl_pkg::ST_FEX:
            begin
                a_op = W'(aex);
                b_op = W'(aex);
            end
            nppl_pkg::ST_FEY:
            begin
                a_op = W'(aey);
                b_op = W'(aey);
                c_op = res;
            end
            default:
            begin
                actrl.start = 1'b0;
            end
        endcase
    end

    // Datapath registers
    always_comb
    begin
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        maxd_next       = maxd_reg;
        prevx_next      = prevx_reg;
        prevy_next      = prevy_reg;
        prev_valid_next = prev_valid_reg;
        x1_next         = x1_reg;
        y1_next         = y1_reg;
        last_next       = last_reg;
        l2_next         = l2_reg;
        lq_next         = lq_reg;
        ux_next         = ux_reg;
        uy_next         = uy_reg;
        dot_next        = dot_reg;
        fx_next         = fx_reg;
        fy_next         = fy_reg;
        bdist_next      = bdist_reg;
        bpx_next        = bpx_reg;
        bpy_next        = bpy_reg;
        bdx_next        = bdx_reg;
        bdy_next        = bdy_reg;
        out_valid_next  = out_valid_reg & out_stall;
        opx_next        = opx_reg;
        opy_next        = opy_reg;
        odx_next        = odx_reg;
        ody_next        = ody_reg;
        odist_next      = odist_reg;

        // New vertex: previous one becomes the segment start
        if (in_acc)
        begin
            x1_next         = prevx_reg;
            y1_next         = prevy_reg;
            prevx_next      = vertex_x;
            prevy_next      = vertex_y;
            prev_valid_next = 1'b1;
            last_next       = last_vertex;
        end

        // Capture unit results
        if (cap)
        begin
            case (state_reg)
                nppl_pkg::ST_L2Y:
                begin
                    l2_next = res[nppl_pkg::L2W-1:0];
                    ux_next = nppl_pkg::Q15_ONE;
                    uy_next = '0;
                end
                nppl_pkg::ST_LQ:   lq_next  = res[nppl_pkg::LQW-1:0];
                nppl_pkg::ST_UX:   ux_next  = dir_sat(res, dx[DW-1]);
                nppl_pkg::ST_UY:   uy_next  = dir_sat(res, dy[DW-1]);
                nppl_pkg::ST_DOT1: dot_next = (ax[DW-1] ^ dx[DW-1]) ? -m_s : m_s;
                nppl_pkg::ST_DOT2: dot_next = dot_sum;
                nppl_pkg::ST_FXD:  fx_next  = dx[DW-1] ? sx1 - q_s : sx1 + q_s;
                nppl_pkg::ST_FYD:  fy_next  = dy[DW-1] ? sy1 - q_s : sy1 + q_s;
                nppl_pkg::ST_E1S, nppl_pkg::ST_E2S, nppl_pkg::ST_FES:
                begin
                    // Strictly closer candidate wins
                    if (cand_dist < bdist_reg)
                    begin
                        bdist_next = cand_dist;
                        bpx_next   = cand_px;
                        bpy_next   = cand_py;
                        bdx_next   = ux_reg;
                        bdy_next   = uy_reg;
                    end
                end
                default:
                begin
                    l2_next = l2_reg;
                end
            endcase
        end

        // Register write, then re-arm
        if (cfg_acc)
        begin
            case (cfg_index)
                nppl_pkg::CFG_QUERY_X:  qx_next   = signed'(cfg_data[C-1:0]);
                nppl_pkg::CFG_QUERY_Y:  qy_next   = signed'(cfg_data[C-1:0]);
                nppl_pkg::CFG_MAX_DIST: maxd_next = cfg_data[OB-1:0];
                default:                maxd_next = maxd_reg;
            endcase
        end

        // Result word out, search restarts
        if (state_reg == nppl_pkg::ST_EMIT && out_free)
        begin
            out_valid_next  = 1'b1;
            opx_next        = bpx_reg;
            opy_next        = bpy_reg;
            odx_next        = bdx_reg;
            ody_next        = bdy_reg;
            odist_next      = bdist_reg;
            prev_valid_next = 1'b0;
        end

        if ((cfg_acc && cfg_index <= nppl_pkg::CFG_MAX_DIST)
            || (state_reg == nppl_pkg::ST_EMIT && out_free))
        begin
            bdist_next = maxd_next;
            bpx_next   = OB'(sqx_next);
            bpy_next   = OB'(sqy_next);
            bdx_next   = nppl_pkg::Q15_ONE;
            bdy_next   = '0;
        end
    end

    // Control and search state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= nppl_pkg::ST_IDLE;
            issued_reg     <= 1'b0;
            qx_reg         <= '0;
            qy_reg         <= '0;
            maxd_reg       <= '1;
            prevx_reg      <= '0;
            prevy_reg      <= '0;
            prev_valid_reg <= 1'b0;
            bdist_reg      <= '1;
            bpx_reg        <= '0;
            bpy_reg        <= '0;
            bdx_reg        <= nppl_pkg::Q15_ONE;
            bdy_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issued_reg     <= issued_next;
            qx_reg         <= qx_next;
            qy_reg         <= qy_next;
            maxd_reg       <= maxd_next;
            prevx_reg      <= prevx_next;
            prevy_reg      <= prevy_next;
            prev_valid_reg <= prev_valid_next;
            bdist_reg      <= bdist_next;
            bpx_reg        <= bpx_next;
            bpy_reg        <= bpy_next;
            bdx_reg        <= bdx_next;
            bdy_reg        <= bdy_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        x1_reg    <= x1_next;
        y1_reg    <= y1_next;
        last_reg  <= last_next;
        l2_reg    <= l2_next;
        lq_reg    <= lq_next;
        ux_reg    <= ux_next;
        uy_reg    <= uy_next;
        dot_reg   <= dot_next;
        fx_reg    <= fx_next;
        fy_reg    <= fy_next;
        opx_reg   <= opx_next;
        opy_reg   <= opy_next;
        odx_reg   <= odx_next;
        ody_reg   <= ody_next;
        odist_reg <= odist_next;
    end

    assign out_valid   = out_valid_reg;
    assign nearest_x   = opx_reg;
    assign nearest_y   = opy_reg;
    assign direction_x = odx_reg;
    assign direction_y = ody_reg;
    assign distance    = odist_reg;

endmodule

>>> src/nppl_checker.sv
module nppl_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 last_vertex,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic [nppl_pkg::OUT_BITS-1:0]        distance,
    input logic [nppl_pkg::OUT_BITS-1:0]        nearest_x
);

    // A held result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // A held result word does not change
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(distance) && $stable(nearest_x))
        else $error("result word changed while stalled");

    // An accepted final vertex always makes the sequencer busy in the cycle after
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_vertex |=> in_stall)
        else $error("final vertex accepted without going busy");

    // A new result only comes out of a busy sequencer
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result word without vertex work");

endmodule

bind nearest_point_on_polylines nppl_checker u_nppl_checker (.*);

>>> bench/nearest_point_on_polylines_test.sv
module nearest_point_on_polylines_test;

    localparam int CB = nppl_pkg::COORD_BITS;
    localparam int OB = nppl_pkg::OUT_BITS;
    localparam int DB = nppl_pkg::DIR_BITS;
    localparam int IB = nppl_pkg::CFG_IDX_BITS;
    localparam int XB = nppl_pkg::CFG_DATA_BITS;

    localparam int IDLE_WAIT   = 1200;   // worst segment latency plus margin
    localparam int WATCH_LIMIT = 60000;  // cycles without any handshake
    localparam int HOLD_LEN    = 4000;

    // first index past the register list
    localparam logic [IB-1:0] BAD_INDEX = 2'd3;

    typedef struct {
        logic signed [OB-1:0] nx;
        logic signed [OB-1:0] ny;
        logic signed [DB-1:0] ux;
        logic signed [DB-1:0] uy;
        logic [OB-1:0]        dval;
    } nearest_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [CB-1:0] vertex_x = '0;
    logic signed [CB-1:0] vertex_y = '0;
    logic starts_polyline = 1'b0;
    logic object_selected = 1'b0;
    logic last_vertex = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [OB-1:0] nearest_x;
    logic signed [OB-1:0] nearest_y;
    logic signed [DB-1:0] direction_x;
    logic signed [DB-1:0] direction_y;
    logic [OB-1:0] distance;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IB-1:0] cfg_index = '0;
    logic [XB-1:0] cfg_data = '0;

    nearest_point_on_polylines uut (.*);

    always #5 clk = ~clk;

    // predictor state
    longint q_x, q_y;
    logic [31:0] radius;
    longint last_vx, last_vy;
    bit last_ok;
    logic [31:0] best_d, best_x, best_y;
    logic signed [15:0] best_ux, best_uy;

    nearest_t expected_nearest[$];
    int failures = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    bit hold_go = 1'b0;

    // ---------------- predictor ----------------
    function automatic logic [63:0] root_floor(logic [127:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if ({64'd0, t} * {64'd0, t} <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic logic [63:0] mag(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [31:0] scaled_dist(longint ex, longint ey);
        logic [127:0] s;
        logic [63:0] r;
        s = {64'd0, mag(ex)} * {64'd0, mag(ex)} + {64'd0, mag(ey)} * {64'd0, mag(ey)};
        r = root_floor(s);
        return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    function automatic logic signed [15:0] unit_comp(longint d, logic [63:0] lq);
        logic [63:0] c;
        c = (mag(d) << 30) / lq;
        if (d < 0)
            return (c >= 64'd32768) ? -16'sd32768 : -16'(signed'(c[15:0]));
        return (c > 64'd32767) ? 16'sd32767 : 16'(c[15:0]);
    endfunction

    function automatic void try_point(logic [31:0] d, longint px, longint py,
                                      logic signed [15:0] ux, logic signed [15:0] uy);
        if (d < best_d)
        begin
            best_d  = d;
            best_x  = px[31:0];
            best_y  = py[31:0];
            best_ux = ux;
            best_uy = uy;
        end
    endfunction

    function automatic void rearm_best();
        longint sx, sy;
        sx = q_x * 256;
        sy = q_y * 256;
        best_d  = radius;
        best_x  = sx[31:0];
        best_y  = sy[31:0];
        best_ux = 16'sd32767;
        best_uy = 16'sd0;
    endfunction

    function automatic void seg_search(longint x1, longint y1, longint x2, longint y2);
        longint dx, dy, dot, fx, fy, sqx, sqy;
        logic [127:0] l2, num;
        logic [63:0] lq, ox, oy;
        logic signed [15:0] ux, uy;
        dx = x2 - x1;
        dy = y2 - y1;
        sqx = q_x * 256;
        sqy = q_y * 256;
        l2 = {64'd0, mag(dx)} * {64'd0, mag(dx)} + {64'd0, mag(dy)} * {64'd0, mag(dy)};
        ux = 16'sd32767;
        uy = 16'sd0;
        if (l2 != 0)
        begin
            lq = root_floor(l2 << 30);
            ux = unit_comp(dx, lq);
            uy = unit_comp(dy, lq);
        end
        try_point(scaled_dist(sqx - x1 * 256, sqy - y1 * 256), x1 * 256, y1 * 256, ux, uy);
        try_point(scaled_dist(sqx - x2 * 256, sqy - y2 * 256), x2 * 256, y2 * 256, ux, uy);
        if (l2 != 0)
        begin
            dot = (q_x - x1) * dx + (q_y - y1) * dy;
            if (dot >= 0 && 128'(dot) <= l2)
            begin
                num = (128'(dot) << 8) * {64'd0, mag(dx)} + (l2 >> 1);
                ox  = 64'(num / l2);
                num = (128'(dot) << 8) * {64'd0, mag(dy)} + (l2 >> 1);
                oy  = 64'(num / l2);
                fx = x1 * 256 + ((dx < 0) ? -longint'(ox) : longint'(ox));
                fy = y1 * 256 + ((dy < 0) ? -longint'(oy) : longint'(oy));
                try_point(scaled_dist(sqx - fx, sqy - fy), fx, fy, ux, uy);
            end
        end
    endfunction

    function automatic void predict_vertex(longint vx, longint vy, bit st, bit sel, bit last);
        nearest_t e;
        if (!st && last_ok && sel)
            seg_search(last_vx, last_vy, vx, vy);
        last_vx = vx;
        last_vy = vy;
        last_ok = 1'b1;
        if (last)
        begin
            e.nx = best_x;
            e.ny = best_y;
            e.ux = best_ux;
            e.uy = best_uy;
            e.dval = best_d;
            expected_nearest = {expected_nearest, e};
            last_ok = 1'b0;
            rearm_best();
        end
    endfunction

    // ---------------- drivers ----------------
    task automatic send_vertex(longint vx, longint vy, bit st, bit sel, bit last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid        <= 1'b1;
        vertex_x        <= CB'(vx);
        vertex_y        <= CB'(vy);
        starts_polyline <= st;
        object_selected <= sel;
        last_vertex     <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_vertex(vx, vy, st, sel, last);
    endtask

    // drop valid and wait until the block has nothing left in flight
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_nearest.size() != 0) @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [IB-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            nppl_pkg::CFG_QUERY_X:  q_x = longint'(signed'(data[CB-1:0]));
            nppl_pkg::CFG_QUERY_Y:  q_y = longint'(signed'(data[CB-1:0]));
            nppl_pkg::CFG_MAX_DIST: radius = data;
            default: return;
        endcase
        rearm_best();
    endtask

    task automatic set_query(logic [31:0] qx, logic [31:0] qy, logic [31:0] r);
        drain();
        write_reg(nppl_pkg::CFG_QUERY_X, qx);
        write_reg(nppl_pkg::CFG_QUERY_Y, qy);
        write_reg(nppl_pkg::CFG_MAX_DIST, r);
    endtask

    function automatic longint clamp_coord(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint pick_coord(longint c);
        logic [31:0] r;
        int m;
        m = $urandom_range(0, 9);
        r = $urandom();
        if (m < 6) return clamp_coord(c + $urandom_range(0, 128) - 64);
        if (m < 8) return clamp_coord(c + $urandom_range(0, 8192) - 4096);
        return longint'(signed'(r[CB-1:0]));
    endfunction

    // ---------------- tests ----------------
    task automatic test_basic();
        // zero-length segment, foot inside, unselected polyline, mid-run restart
        send_vertex(100, 0, 1, 1, 0);
        send_vertex(100, 0, 0, 1, 0);
        send_vertex(-5, 3, 0, 1, 0);
        send_vertex(5, 3, 0, 1, 0);
        send_vertex(40, 40, 0, 1, 1);
        send_vertex(-1, 1, 1, 0, 0);
        send_vertex(1, 1, 0, 0, 0);
        send_vertex(7, 90, 1, 1, 0);
        send_vertex(9, 95, 0, 1, 1);
        // single vertex search, then a segment whose foot falls outside
        send_vertex(3, 3, 1, 1, 1);
        send_vertex(10, 10, 0, 1, 1);
        send_vertex(20, 0, 1, 1, 0);
        send_vertex(30, 0, 0, 1, 1);
    endtask

    task automatic test_extremes();
        set_query(32'h007F_FFFF, 32'hFF80_0000, 32'hFFFF_FFFF);
        send_vertex(-8388608, 8388607, 1, 1, 0);
        send_vertex(8388607, 8388607, 0, 1, 1);
        send_vertex(-8388608, -8388608, 1, 1, 0);
        send_vertex(8388607, 8388607, 0, 1, 1);
        set_query(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        send_vertex(-8388608, -8388608, 1, 1, 0);
        send_vertex(8388607, 8388607, 0, 1, 0);
        send_vertex(8388607, -8388608, 0, 1, 1);
    endtask

    task automatic test_nothing_closer();
        set_query(32'h0000_0011, 32'hFFFF_FFEE, 32'h0000_0000);
        send_vertex(17, -18, 1, 1, 0);
        send_vertex(50, -18, 0, 1, 1);
        drain();
        write_reg(nppl_pkg::CFG_MAX_DIST, 32'h0000_0001);
        write_reg(BAD_INDEX, 32'h1234_5678);   // out of range index, ignored
        send_vertex(17, -18, 1, 1, 0);
        send_vertex(17, -18, 0, 1, 1);
    endtask

    task automatic test_random(int n);
        int sent;
        int nv;
        int npl;
        bit sel;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                // noise: arbitrary flags
                send_vertex(pick_coord(q_x), pick_coord(q_y), $urandom_range(0, 1),
                            $urandom_range(0, 1), $urandom_range(0, 1));
                sent++;
            end
            else
            begin
                npl = $urandom_range(1, 3);
                for (int p = 0; p < npl; p++)
                begin
                    nv  = $urandom_range(1, 4);
                    sel = ($urandom_range(0, 7) != 0);
                    for (int v = 0; v < nv; v++)
                    begin
                        send_vertex(pick_coord(q_x), pick_coord(q_y), v == 0, sel,
                                    (p == npl - 1) && (v == nv - 1));
                        sent++;
                    end
                end
            end
        end
    endtask

    task automatic test_long_hold();
        hold_go = ~hold_go;
        for (int i = 0; i < 12; i++)
            send_vertex(pick_coord(q_x), pick_coord(q_y), i % 2 == 0, 1, i % 2 == 1);
        drain();
    endtask

    task automatic test_settings();
        set_query($urandom(), $urandom(), $urandom());
        test_random(150);
        set_query($urandom(), $urandom(), 32'h0000_4000);
        test_random(150);
        set_query($urandom(), $urandom(), 32'hFFFF_FFFF);
        test_random(150);
        set_query(32'h0080_0000, 32'h007F_FFFF, 32'h0000_0000);
        test_random(100);
        set_query($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
                  32'hFFFF_FFFF);
        test_random(300);
    endtask

    // ---------------- receiver, checker, watchdog ----------------
    int hold_left = 0;
    bit hold_seen = 1'b0;
    always @(posedge clk)
    begin
        if (hold_go != hold_seen)
        begin
            hold_seen <= hold_go;
            hold_left <= HOLD_LEN;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 9) < 3) && ($urandom_range(0, 3) != 0);
    end

    // compare each accepted word with the oldest expectation
    always @(posedge clk)
    begin
        nearest_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_nearest.size() == 0)
            begin
                $error("unexpected result word");
                failures++;
            end
            else
            begin
                e = expected_nearest.pop_front();
                if (nearest_x !== e.nx)
                begin
                    $error("nearest_x exp %0d got %0d", e.nx, nearest_x);
                    failures++;
                end
                if (nearest_y !== e.ny)
                begin
                    $error("nearest_y exp %0d got %0d", e.ny, nearest_y);
                    failures++;
                end
                if (direction_x !== e.ux)
                begin
                    $error("direction_x exp %0d got %0d", e.ux, direction_x);
                    failures++;
                end
                if (direction_y !== e.uy)
                begin
                    $error("direction_y exp %0d got %0d", e.uy, direction_y);
                    failures++;
                end
                if (distance !== e.dval)
                begin
                    $error("distance exp %0d got %0d", e.dval, distance);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("nearest_point_on_polylines_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        q_x = 0;
        q_y = 0;
        radius = 32'hFFFF_FFFF;
        last_vx = 0;
        last_vy = 0;
        last_ok = 1'b0;
        rearm_best();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic();
        test_extremes();
        test_nothing_closer();
        test_settings();
        test_long_hold();
        drain();
        if (failures == 0 && expected_nearest.size() == 0)
            $display("nearest_point_on_polylines_test: PASS");
        else
            $display("nearest_point_on_polylines_test: FAIL");
        $finish;
    end

endmodule

>>> sim.f
src/nppl_pkg.sv
src/nppl_arith.sv
src/nearest_point_on_polylines.sv
src/nppl_checker.sv
bench/nearest_point_on_polylines_test.sv
